>>> design/oks_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oks_pkg: shared types for the ordered key set
// request codes and the controller to datapath command and status structs
// ----------------------------------------------------------------------------
package oks_pkg;

	typedef enum logic [2:0] {
		FUNC_INSERT = 3'd0,
		FUNC_REMOVE = 3'd1,
		FUNC_MEMBER = 3'd2,
		FUNC_SUCC   = 3'd3,
		FUNC_PRED   = 3'd4,
		FUNC_MIN    = 3'd5,
		FUNC_MAX    = 3'd6,
		FUNC_NONE   = 3'd7
	} func_t;

	// controller commands to the datapath
	typedef struct packed {
		logic clr;        // write zero at current node, step to next node
		logic load;       // capture request, point at leaf, read leaf
		logic wr;         // write adjusted count at current node
		logic rd_sib;     // read sibling of current node
		logic rd_child;   // read preferred child of current node
		logic go_up;      // move to parent and read it
		logic go_sib;     // move to sibling
		logic go_child;   // move to child picked from read data
		logic go_root;    // point at root and read it
		logic set_found;  // mark key present
		logic set_hit;    // mark search hit and capture leaf key
		logic cnt_inc;
		logic cnt_dec;
	} oks_cmd_t;

	// datapath status to the controller
	typedef struct packed {
		logic at_root;
		logic at_leaf;
		logic at_last;    // last node of the clearing pass
		logic is_left;
		logic rd_nz;      // registered read data nonzero
	} oks_sts_t;

endpackage
`default_nettype wire

>>> design/oks_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oks_if: valid/ready channel
// carries one transaction payload of generic width
// ----------------------------------------------------------------------------
interface oks_if #(parameter int W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/oks_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oks_datapath: node pointer, count memory and result registers
// heap-ordered count tree in one memory with a registered read port
// ----------------------------------------------------------------------------
module oks_datapath import oks_pkg::*; #(
	parameter int KEY_BITS = 10
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire oks_cmd_t       cmd,
	input  wire [KEY_BITS-1:0]  key,
	input  wire                 to_max,   // descend preferring the high child
	input  wire                 add,      // write direction
	output oks_sts_t            sts,
	output logic                found,
	output logic [KEY_BITS-1:0] result_key,
	output logic [KEY_BITS:0]   member_count
);
	localparam int NB = KEY_BITS + 1;
	localparam int DEPTH = (1 << NB) - 1;
	localparam logic [NB-1:0] LEAF_BASE = NB'((1 << KEY_BITS) - 1);
	localparam logic [NB-1:0] LAST_NODE = NB'(DEPTH - 1);

	logic [KEY_BITS:0] mem [DEPTH];
	logic [NB-1:0] node_q;
	logic [KEY_BITS:0] rdata_q;
	logic [KEY_BITS:0] wdata;
	logic [NB-1:0] raddr;
	logic found_q;
	logic [KEY_BITS-1:0] res_q;
	logic [KEY_BITS:0] cnt_q;

	logic [NB-1:0] parent, sib, lo, hi, child;
	assign parent = (node_q - NB'(1)) >> 1;
	assign sib    = node_q[0] ? node_q + NB'(1) : node_q - NB'(1);
	assign lo     = {node_q[NB-2:0], 1'b1};
	assign hi     = lo + NB'(1);
	// child read issues the preferred child; pick uses its data
	assign child  = to_max ? (rdata_q != '0 ? hi : lo) : (rdata_q != '0 ? lo : hi);

	// read address: leaf on load, root, parent, sibling or preferred child when asked, else the current node
	always_comb begin
		priority if (cmd.load) raddr = LEAF_BASE + NB'(key);
		else if (cmd.go_root)  raddr = '0;
		else if (cmd.go_up)    raddr = parent;
		else if (cmd.rd_sib)   raddr = sib;
		else if (cmd.rd_child) raddr = to_max ? hi : lo;
		else                   raddr = node_q;
	end

	always_comb begin
		priority if (cmd.clr) wdata = '0;
		else if (add)         wdata = rdata_q + 1'b1;
		else                  wdata = rdata_q - 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.wr || cmd.clr) mem[node_q] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q  <= '0;
			found_q <= 1'b0;
			res_q   <= '0;
			cnt_q   <= '0;
		end else begin
			if (cmd.load)          node_q <= LEAF_BASE + NB'(key);
			else if (cmd.go_root)  node_q <= '0;
			else if (cmd.clr)      node_q <= node_q + NB'(1);
			else if (cmd.go_up)    node_q <= parent;
			else if (cmd.go_sib)   node_q <= sib;
			else if (cmd.go_child) node_q <= child;

			if (cmd.load) begin
				found_q <= 1'b0;
				res_q   <= '0;
			end else if (cmd.set_hit) begin
				found_q <= 1'b1;
				res_q   <= KEY_BITS'(node_q - LEAF_BASE);
			end else if (cmd.set_found) begin
				found_q <= 1'b1;
			end

			if (cmd.cnt_inc)      cnt_q <= cnt_q + 1'b1;
			else if (cmd.cnt_dec) cnt_q <= cnt_q - 1'b1;
		end
	end

	assign sts.at_root   = (node_q == '0);
	assign sts.at_leaf   = (node_q >= LEAF_BASE);
	assign sts.at_last   = (node_q == LAST_NODE);
	assign sts.is_left   = node_q[0];
	assign sts.rd_nz     = (rdata_q != '0);

	assign found        = found_q;
	assign result_key   = res_q;
	assign member_count = cnt_q;
endmodule
`default_nettype wire

>>> design/oks_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oks_ctrl: request sequencer
// drives reset clearing, path updates, climbs and descents
// ----------------------------------------------------------------------------
module oks_ctrl import oks_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire [2:0]          in_func,
	output logic               out_valid,
	input  wire                out_ready,
	input  wire oks_sts_t      sts,
	output oks_cmd_t           cmd,
	output logic               to_max,
	output logic               add,
	output logic               clr_active
);
	typedef enum logic [9:0] {
		S_CLR   = 10'b0000000001,
		S_IDLE  = 10'b0000000010,
		S_LCHK  = 10'b0000000100, // decide on leaf data
		S_UPD   = 10'b0000001000, // write node, step up
		S_CLIMB = 10'b0000010000, // issue sibling read
		S_CCHK  = 10'b0000100000,
		S_RROOT = 10'b0001000000,
		S_DRD   = 10'b0010000000, // issue child read, or mark hit at a leaf
		S_DCHK  = 10'b0100000000,
		S_DONE  = 10'b1000000000
	} state_t;

	state_t st_q;
	func_t f_q;

	assign to_max = (f_q == FUNC_MAX) || (f_q == FUNC_PRED);
	assign add    = (f_q == FUNC_INSERT);
	assign in_ready  = (st_q == S_IDLE);
	assign out_valid = (st_q == S_DONE);
	assign clr_active = (st_q == S_CLR);

	always_comb begin
		cmd = '0;
		unique case (st_q)
			S_CLR: begin
				cmd.clr = 1'b1;
				if (sts.at_last) cmd.go_root = 1'b1;
			end
			S_IDLE: if (in_valid) cmd.load = 1'b1;
			S_LCHK: begin
				unique case (f_q)
					FUNC_INSERT: if (sts.rd_nz) cmd.set_found = 1'b1;
					else begin
						cmd.wr = 1'b1; cmd.cnt_inc = 1'b1; cmd.go_up = 1'b1;
					end
					FUNC_REMOVE: if (sts.rd_nz) begin
						cmd.set_found = 1'b1;
						cmd.wr = 1'b1; cmd.cnt_dec = 1'b1; cmd.go_up = 1'b1;
					end
					FUNC_MEMBER: if (sts.rd_nz) cmd.set_found = 1'b1;
					FUNC_MIN, FUNC_MAX: cmd.go_root = 1'b1;
					default: ;
				endcase
			end
			S_UPD: begin
				cmd.wr = 1'b1;
				if (!sts.at_root) cmd.go_up = 1'b1;
			end
			S_CLIMB: if (!sts.at_root) cmd.rd_sib = 1'b1;
			S_CCHK: begin
				if (sts.rd_nz && (sts.is_left != to_max)) cmd.go_sib = 1'b1;
				else cmd.go_up = 1'b1;
			end
			S_RROOT: ;
			S_DRD: begin
				if (sts.at_leaf) cmd.set_hit = 1'b1;
				else cmd.rd_child = 1'b1;
			end
			S_DCHK: cmd.go_child = 1'b1;
			S_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_CLR;
			f_q   <= FUNC_NONE;
		end else begin
			unique case (st_q)
				S_CLR: if (sts.at_last) st_q <= S_IDLE;
				S_IDLE: if (in_valid) begin
					f_q  <= func_t'(in_func);
					st_q <= S_LCHK;
				end
				S_LCHK: begin
					unique case (f_q)
						FUNC_INSERT: st_q <= sts.rd_nz ? S_DONE : S_UPD;
						FUNC_REMOVE: st_q <= sts.rd_nz ? S_UPD : S_DONE;
						FUNC_SUCC, FUNC_PRED: st_q <= S_CLIMB;
						FUNC_MIN, FUNC_MAX: st_q <= S_RROOT;
						default: st_q <= S_DONE;
					endcase
				end
				S_UPD: if (sts.at_root) st_q <= S_DONE;
				S_CLIMB: st_q <= sts.at_root ? S_DONE : S_CCHK;
				S_CCHK: begin
					if (sts.rd_nz && (sts.is_left != to_max)) st_q <= S_DRD;
					else st_q <= S_CLIMB;
				end
				S_RROOT: st_q <= sts.rd_nz ? S_DRD : S_DONE;
				S_DRD: st_q <= sts.at_leaf ? S_DONE : S_DCHK;
				S_DCHK: st_q <= S_DRD;
				S_DONE: if (out_ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> design/ordered_key_set_successor_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_key_set_successor_top: ordered key set with neighbor search
// insert, remove, member test, successor, predecessor, minimum, maximum
// ----------------------------------------------------------------------------
// One request transaction in, one result transaction out, one at a time:
// req.ready is high only while the block is idle and the result is held
// until rsp.ready. Counts of members under every prefix live in one memory
// of 2^(KEY_BITS+1)-1 words with one read and one write per cycle. An insert
// of a new key or a remove of a member writes once per tree level, from the
// leaf up to the root. A member test, a duplicate insert, a remove of an
// absent key or the unused code only reads the leaf. Successor and
// predecessor climb toward the root and then descend to a leaf; minimum
// and maximum read the root and descend. After reset a clearing pass
// writes zero to each of the 2^(KEY_BITS+1)-1 words before the first
// request is taken.
module ordered_key_set_successor_top import oks_pkg::*; #(
	parameter int KEY_BITS = 10
) (
	input wire clk,
	input wire arst_n,
	oks_if.sink   req,
	oks_if.source rsp
);
	logic [2:0] func;
	logic [KEY_BITS-1:0] key;
	logic found;
	logic [KEY_BITS-1:0] result_key;
	logic [KEY_BITS:0] member_count;
	oks_cmd_t cmd;
	oks_sts_t sts;
	logic to_max, add, clr_active;

	assign func = req.data[2:0];
	assign key  = req.data[KEY_BITS+2:3];
	assign rsp.data = {member_count, result_key, found};

	oks_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(req.valid), .in_ready(req.ready), .in_func(func),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.sts, .cmd, .to_max, .add, .clr_active
	);

	oks_datapath #(.KEY_BITS(KEY_BITS)) u_dp (
		.clk, .arst_n, .cmd, .key, .to_max, .add, .sts,
		.found, .result_key, .member_count
	);

	// no request taken during clearing
	a_clr_block: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active |-> !req.ready) else $error("request during clear");
	// result only offered outside the request side
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && rsp.valid)) else $error("ready and valid overlap");
	// a stalled result transaction holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
		else $error("result dropped or changed under stall");
endmodule
`default_nettype wire
